/* src/iol_pkg.sv */
`default_nettype none

package iol_pkg;

	// Number of list cells.
	localparam int DEPTH = 16;

	// Fixed widths of the item and result fields.
	localparam int VAL_W = 32;
	localparam int POS_W = 5;
	localparam int LEN_W = 5;

	// Cell index, entry count and the common width used for comparisons.
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [2:0] {
		ACT_APPEND     = 3'd0,
		ACT_INSERT     = 3'd1,
		ACT_REMOVE     = 3'd2,
		ACT_REMOVE_FST = 3'd3,
		ACT_REMOVE_LST = 3'd4,
		ACT_DUMP       = 3'd5,
		ACT_CLEAR      = 3'd6
	} action_t;

	// The operation that every cell applies.
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_APPEND,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [CMP_W-1:0]  pos;
		logic [CMP_W-1:0]  count;
		logic [VAL_W-1:0]  value;
	} cell_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

	function automatic logic [CMP_W-1:0] idx_ext(input logic [IDX_W-1:0] i);
		return CMP_W'(i);
	endfunction

	function automatic logic [CMP_W-1:0] cnt_ext(input logic [CNT_W-1:0] c);
		return CMP_W'(c);
	endfunction

	function automatic logic [CMP_W-1:0] pos_ext(input logic [POS_W-1:0] p);
		return CMP_W'(p);
	endfunction

	function automatic logic [LEN_W-1:0] len_of(input logic [CNT_W-1:0] c);
		return LEN_W'(c);
	endfunction

endpackage

`default_nettype wire

/* src/iol_cell.sv */
`default_nettype none

// One list slot. It reloads from its left neighbor, its right neighbor,
// the broadcast value or the head of the chain, as the command and its own
// index say.
module iol_cell (
	input  wire logic                             clk,
	input  wire logic [iol_pkg::IDX_W-1:0]        idx,
	input  wire iol_pkg::cell_cmd_t               cmd,
	input  wire logic [iol_pkg::VAL_W-1:0]        left_val,
	input  wire logic [iol_pkg::VAL_W-1:0]        right_val,
	input  wire logic [iol_pkg::VAL_W-1:0]        wrap_val,
	output logic      [iol_pkg::VAL_W-1:0]        val
);

	logic [iol_pkg::VAL_W-1:0] val_q;
	logic [iol_pkg::VAL_W-1:0] val_d;
	logic [iol_pkg::CMP_W-1:0] idx_e;
	logic [iol_pkg::CMP_W-1:0] idx_nx;

	assign idx_e  = iol_pkg::idx_ext(idx);
	assign idx_nx = idx_e + 1'b1;

	always_comb begin
		val_d = val_q;
		case (cmd.op)
			iol_pkg::CELL_APPEND: begin
				if (idx_e == cmd.count) val_d = cmd.value;
			end
			iol_pkg::CELL_INSERT: begin
				if (idx_e == cmd.pos) val_d = cmd.value;
				else if (idx_e > cmd.pos) val_d = left_val;
			end
			iol_pkg::CELL_REMOVE: begin
				if (idx_e >= cmd.pos) val_d = right_val;
			end
			iol_pkg::CELL_ROTATE: begin
				if (idx_nx < cmd.count) val_d = right_val;
				else if (idx_nx == cmd.count) val_d = wrap_val;
			end
			default: val_d = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	assign val = val_q;

endmodule

`default_nettype wire

/* src/indexed_ordered_list_core.sv */
// An edit or a clear gives its single result word in the cycle after its acceptance.
// Dump: words leave the dump state one a cycle while the output is not stalled;
// edit words are taken one per cycle when the output is not stalled and no dump runs; a dump
// holds the input for all its entries, the chain rotating one cell per emitted word.
// Reset: arst_n clears the entry count, the state and the output valid; cell
// contents are not reset and are only read below the count.
`default_nettype none

module indexed_ordered_list_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Input channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [2:0]                        action,
	input  wire logic [iol_pkg::POS_W-1:0]         position,
	input  wire logic signed [iol_pkg::VAL_W-1:0]  item_value,
	// Output channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   ok,
	output logic                                   entry_valid,
	output logic signed [iol_pkg::VAL_W-1:0]       entry_value,
	output logic                                   last,
	output logic      [iol_pkg::LEN_W-1:0]         length
);

	// Control state.
	iol_pkg::state_t                 state_q, state_d;
	logic [iol_pkg::CNT_W-1:0]       count_q, count_d;
	logic [iol_pkg::CNT_W-1:0]       dump_idx_q, dump_idx_d;

	// Output register: it decouples the result from the next accepted word.
	logic                            out_valid_q, out_valid_d;
	logic                            ok_q, ok_d;
	logic                            entry_valid_q, entry_valid_d;
	logic [iol_pkg::VAL_W-1:0]       entry_value_q, entry_value_d;
	logic                            last_q, last_d;
	logic [iol_pkg::LEN_W-1:0]       length_q, length_d;

	logic                            in_accept;
	logic                            out_free;
	iol_pkg::cell_cmd_t              cmd;
	logic [iol_pkg::VAL_W-1:0]       cell_val [iol_pkg::DEPTH];

	logic                            full;
	logic [iol_pkg::CMP_W-1:0]       pos_e;
	logic [iol_pkg::CMP_W-1:0]       cnt_e;
	logic [iol_pkg::CNT_W-1:0]       dump_idx_nx;

	// The output register can take a new word when it is empty or being drained.
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q == iol_pkg::ST_DUMP) || !out_free;
	assign in_accept = in_valid && !in_stall;

	assign full        = (count_q == iol_pkg::CNT_W'(iol_pkg::DEPTH));
	assign pos_e       = iol_pkg::pos_ext(position);
	assign cnt_e       = iol_pkg::cnt_ext(count_q);
	assign dump_idx_nx = dump_idx_q + 1'b1;

	// Decoder and dump sequencer. Edits update the whole chain at once;
	// a dump rotates the occupied cells by one per word, reading cell zero,
	// so after the count of rotations the list is back in its original order.
	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		dump_idx_d    = dump_idx_q;
		out_valid_d   = out_valid_q && out_stall;
		ok_d          = ok_q;
		entry_valid_d = entry_valid_q;
		entry_value_d = entry_value_q;
		last_d        = last_q;
		length_d      = length_q;

		cmd.op    = iol_pkg::CELL_HOLD;
		cmd.pos   = pos_e;
		cmd.count = cnt_e;
		cmd.value = item_value;

		unique case (state_q)
			iol_pkg::ST_IDLE: begin
				if (in_accept) begin
					// A plain result word unless a dump says otherwise.
					ok_d          = 1'b0;
					entry_valid_d = 1'b0;
					entry_value_d = '0;
					last_d        = 1'b1;
					out_valid_d   = 1'b1;
					unique case (iol_pkg::action_t'(action))
						iol_pkg::ACT_APPEND: begin
							if (!full) begin
								cmd.op  = iol_pkg::CELL_APPEND;
								count_d = count_q + 1'b1;
								ok_d    = 1'b1;
							end
						end
						iol_pkg::ACT_INSERT: begin
							if (!full && (pos_e <= cnt_e)) begin
								cmd.op  = iol_pkg::CELL_INSERT;
								count_d = count_q + 1'b1;
								ok_d    = 1'b1;
							end
						end
						iol_pkg::ACT_REMOVE: begin
							if (pos_e < cnt_e) begin
								cmd.op  = iol_pkg::CELL_REMOVE;
								count_d = count_q - 1'b1;
								ok_d    = 1'b1;
							end
						end
						iol_pkg::ACT_REMOVE_FST: begin
							if (count_q != '0) begin
								cmd.op  = iol_pkg::CELL_REMOVE;
								cmd.pos = '0;
								count_d = count_q - 1'b1;
								ok_d    = 1'b1;
							end
						end
						iol_pkg::ACT_REMOVE_LST: begin
							if (count_q != '0) begin
								count_d = count_q - 1'b1;
								ok_d    = 1'b1;
							end
						end
						iol_pkg::ACT_DUMP: begin
							ok_d = 1'b1;
							if (count_q != '0) begin
								// Words come out of the dump state instead.
								out_valid_d = out_valid_q && out_stall;
								ok_d        = ok_q;
								entry_value_d = entry_value_q;
								entry_valid_d = entry_valid_q;
								last_d      = last_q;
								dump_idx_d  = '0;
								state_d     = iol_pkg::ST_DUMP;
							end
						end
						iol_pkg::ACT_CLEAR: begin
							count_d = '0;
							ok_d    = 1'b1;
						end
						default: begin
							ok_d = 1'b0;
						end
					endcase
					if (state_d == iol_pkg::ST_IDLE) begin
						length_d = iol_pkg::len_of(count_d);
					end
				end
			end
			iol_pkg::ST_DUMP: begin
				if (out_free) begin
					cmd.op        = iol_pkg::CELL_ROTATE;
					out_valid_d   = 1'b1;
					ok_d          = 1'b1;
					entry_valid_d = 1'b1;
					entry_value_d = cell_val[0];
					last_d        = (dump_idx_nx == count_q);
					length_d      = iol_pkg::len_of(count_q);
					dump_idx_d    = dump_idx_nx;
					if (dump_idx_nx == count_q) state_d = iol_pkg::ST_IDLE;
				end
			end
			default: state_d = iol_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iol_pkg::ST_IDLE;
			count_q     <= '0;
			dump_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			dump_idx_q  <= dump_idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		ok_q          <= ok_d;
		entry_valid_q <= entry_valid_d;
		entry_value_q <= entry_value_d;
		last_q        <= last_d;
		length_q      <= length_d;
	end

	// The chain of cells. Cell zero's left neighbor is the incoming value,
	// the last cell's right neighbor is tied to cell zero, and every cell sees
	// cell zero as the wrap value for rotation.
	for (genvar i = 0; i < iol_pkg::DEPTH; i++) begin : g_cell
		logic [iol_pkg::VAL_W-1:0] left_w;
		logic [iol_pkg::VAL_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = item_value;
		end else begin : g_mid_l
			assign left_w = cell_val[i-1];
		end
		if (i == iol_pkg::DEPTH - 1) begin : g_end
			assign right_w = cell_val[0];
		end else begin : g_mid_r
			assign right_w = cell_val[i+1];
		end
		iol_cell u_cell (
			.clk       (clk),
			.idx       (iol_pkg::IDX_W'(i)),
			.cmd       (cmd),
			.left_val  (left_w),
			.right_val (right_w),
			.wrap_val  (cell_val[0]),
			.val       (cell_val[i])
		);
	end

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign entry_valid = entry_valid_q;
	assign entry_value = entry_value_q;
	assign last        = last_q;
	assign length      = length_q;

	// The count never goes past the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= iol_pkg::CNT_W'(iol_pkg::DEPTH))
		else $error("entry count above depth");

	// While dumping, the word index stays below the count.
	a_dump_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == iol_pkg::ST_DUMP) |-> (dump_idx_q < count_q))
		else $error("dump index beyond count");

	// A dumped entry is always reported as a success.
	a_dump_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && entry_valid_q) |-> ok_q)
		else $error("dumped entry without ok");

	// The list does not change length during a dump.
	a_dump_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == iol_pkg::ST_DUMP) |=> $stable(count_q))
		else $error("count changed during dump");

endmodule

`default_nettype wire
